### hdl/paa_pkg.sv
// Package for periodic allocation advance: status codes, field codes and
// configuration register indexes. No dependencies.
`default_nettype none
package paa_pkg;

    typedef enum logic [3:0] {
        ST_ADVANCED     = 4'd0,
        ST_INACTIVE     = 4'd1,
        ST_BAD_ALLOC    = 4'd2,
        ST_ZERO_LEN     = 4'd3,
        ST_SINGLE_PAST  = 4'd4,
        ST_SINGLE_PEND  = 4'd5,
        ST_ZERO_REPEAT  = 4'd6,
        ST_BAD_REPEAT   = 4'd7,
        ST_ZERO_PERIOD  = 4'd8,
        ST_EXPIRED      = 4'd9
    } t_status;

    localparam logic [1:0] KIND_DOWN    = 2'd0;
    localparam logic [1:0] KIND_UP      = 2'd1;
    localparam logic [1:0] KIND_BIDI    = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam logic [2:0] REP_SINGLE      = 3'd0;
    localparam logic [2:0] REP_FRAMES      = 3'd1;
    localparam logic [2:0] REP_FRAME_GRP   = 3'd2;
    localparam logic [2:0] REP_SUBSLOTS    = 3'd3;
    localparam logic [2:0] REP_SUBSLOT_GRP = 3'd4;
    localparam logic [2:0] REP_RESERVED    = 3'd7;

    localparam logic [1:0] ROLE_FIXED    = 2'd0;
    localparam logic [1:0] ROLE_PORTABLE = 2'd1;

    localparam logic [1:0] CFG_FRAME_TICKS  = 2'd0;
    localparam logic [1:0] CFG_SYMBOL_TICKS = 2'd1;
    localparam logic [1:0] CFG_DEVICE_ROLE  = 2'd2;
    localparam logic [1:0] CFG_ANCHOR       = 2'd3;

    localparam logic [7:0]  VALIDITY_UNLIMITED = 8'hFF;
    localparam logic [31:0] FRAME_UNKNOWN      = 32'hFFFF_FFFF;
    localparam logic [3:0]  MU_MAX             = 4'd7;
    localparam logic [3:0]  SUBSLOT_SYMBOLS    = 4'd10;

endpackage
`default_nettype wire

### hdl/paa_req_if.sv
// Request channel interface: one allocation record per transaction.
// No dependencies.
`default_nettype none
interface paa_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] now_time;
    logic [3:0]  mu_code;
    logic        rec_active;
    logic [1:0]  alloc_kind;
    logic [2:0]  repeat_kind;
    logic [7:0]  down_length;
    logic [7:0]  up_length;
    logic [7:0]  repeat_count;
    logic [7:0]  validity_frames;
    logic [31:0] first_frame;
    logic [63:0] next_time;
    logic        init_time_set;

    modport source (output valid, now_time, mu_code, rec_active, alloc_kind, repeat_kind,
                    down_length, up_length, repeat_count, validity_frames, first_frame,
                    next_time, init_time_set, input ready);
    modport sink (input valid, now_time, mu_code, rec_active, alloc_kind, repeat_kind,
                  down_length, up_length, repeat_count, validity_frames, first_frame,
                  next_time, init_time_set, output ready);
endinterface
`default_nettype wire

### hdl/paa_res_if.sv
// Result channel interface: one updated record state per transaction.
// Depends on paa_pkg.
`default_nettype none
interface paa_res_if;
    logic               valid;
    logic               ready;
    logic               out_active;
    logic [63:0]        out_next_time;
    paa_pkg::t_status   status;

    modport source (output valid, out_active, out_next_time, status, input ready);
    modport sink (input valid, out_active, out_next_time, status, output ready);
endinterface
`default_nettype wire

### hdl/paa_div.sv
// Shared restoring divider, one quotient bit per cycle: 64-bit dividend,
// 32-bit divisor. No dependencies.
`default_nettype none
module paa_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quot,
    output logic [31:0]      o_rem
);
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_quot;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [32:0] n_trial;
    logic        n_ge;

    always_comb begin
        n_trial = {r_rem, r_quot[63]};
        n_ge    = n_trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[62:0], n_ge};
            r_rem  <= n_ge ? 32'(n_trial - {1'b0, r_div}) : n_trial[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

### hdl/periodic_allocation_advance_top.sv
// Periodic allocation advance: sequencer around the shared divider.
// Depends on paa_pkg, paa_req_if, paa_res_if, paa_div.
//
// Usage: i_req carries one allocation record plus the current modem time per
// transaction; o_res returns exactly one transaction with the active flag,
// the next occurrence time and a status code. Configuration (frame ticks,
// symbol ticks, device role, frame-zero anchor) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this.
// Inactive, bad and zero-length records finish without division; a
// repeating record with catch-up and validity check uses two 64-bit
// divisions (catch-up, frame number) on the shared divider. One record is
// processed at a time; i_req.ready is high only while the sequencer waits
// for a record, so the next record is taken at the earliest in the cycle
// after the result is loaded.
// The result sits in an output register: a new record is taken while the
// previous result is still waiting, and the sequencer holds its finished
// result until o_res.ready frees the register.
// Reset (synchronous, active low) restores the configuration defaults,
// idles the sequencer and drops o_res.valid.
`default_nettype none
module periodic_allocation_advance_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    paa_req_if.sink     i_req,
    paa_res_if.source   o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    import paa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_CHK, S_DEC, S_DIV1, S_FRM, S_DIV2, S_VAL, S_DONE
    } t_state;

    t_state      r_state;
    logic [23:0] r_frame_ticks;
    logic [15:0] r_symbol_ticks;
    logic [1:0]  r_role;
    logic [63:0] r_anchor;

    logic [63:0] r_now;
    logic [3:0]  r_mu;
    logic        r_act_in;
    logic [1:0]  r_kind;
    logic [2:0]  r_rep;
    logic [7:0]  r_dlen;
    logic [7:0]  r_ulen;
    logic [7:0]  r_rcnt;
    logic [7:0]  r_valid;
    logic [31:0] r_first;
    logic [63:0] r_next;
    logic        r_init;
    logic [19:0] r_sub;
    logic [7:0]  r_len;
    logic [27:0] r_span;
    logic [31:0] r_period;
    logic        r_neg;
    logic [31:0] r_frame;
    logic        r_res_act;
    t_status     r_res_st;

    logic        r_out_valid;
    logic        r_out_act;
    logic [63:0] r_out_next;
    t_status     r_out_st;

    logic        n_div_start;
    logic [63:0] n_div_dividend;
    logic [31:0] n_div_divisor;
    logic        w_div_done;
    logic [63:0] w_div_quot;
    logic [31:0] w_div_rem;

    logic [15:0] n_sym_sh;
    logic        n_rep_frame;
    logic        n_rep_sub;
    logic [63:0] n_diff;
    logic [31:0] n_elapsed;
    logic [31:0] n_q32;

    always_comb begin
        n_sym_sh    = r_symbol_ticks >> r_mu;
        n_rep_frame = (r_rep == REP_FRAMES) || (r_rep == REP_FRAME_GRP);
        n_rep_sub   = (r_rep == REP_SUBSLOTS) || (r_rep == REP_SUBSLOT_GRP);
        n_diff      = r_next - r_anchor;
        n_elapsed   = r_frame - r_first;
        n_q32       = w_div_quot[31:0];
        n_div_start    = 1'b0;
        n_div_dividend = n_diff[63] ? 64'(64'd0 - n_diff) : n_diff;
        n_div_divisor  = {8'd0, r_frame_ticks};
        if (r_state == S_DEC) begin
            n_div_dividend = r_now - r_next;
            n_div_divisor  = r_period;
            n_div_start    = n_rep_frame || n_rep_sub;
            n_div_start    = n_div_start && (r_rcnt != 8'd0) && (r_rep != REP_SINGLE)
                             && (r_period != 32'd0) && !(r_next == 64'd0 && r_init)
                             && (r_next <= r_now);
        end else if (r_state == S_FRM) begin
            n_div_start = (r_valid != VALIDITY_UNLIMITED) && (r_first != FRAME_UNKNOWN)
                          && (r_frame_ticks != 24'd0);
        end
    end

    paa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_div_dividend),
        .i_divisor  (n_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_ticks  <= 24'd691200;
            r_symbol_ticks <= 16'd2880;
            r_role         <= ROLE_FIXED;
            r_anchor       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_TICKS:  r_frame_ticks  <= i_cfg_data[23:0];
                CFG_SYMBOL_TICKS: r_symbol_ticks <= i_cfg_data[15:0];
                CFG_DEVICE_ROLE:  r_role         <= i_cfg_data[1:0];
                CFG_ANCHOR:       r_anchor       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_now    <= i_req.now_time;
                        r_mu     <= i_req.mu_code;
                        r_act_in <= i_req.rec_active;
                        r_kind   <= i_req.alloc_kind;
                        r_rep    <= i_req.repeat_kind;
                        r_dlen   <= i_req.down_length;
                        r_ulen   <= i_req.up_length;
                        r_rcnt   <= i_req.repeat_count;
                        r_valid  <= i_req.validity_frames;
                        r_first  <= i_req.first_frame;
                        r_next   <= i_req.next_time;
                        r_init   <= i_req.init_time_set;
                        r_state  <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_sub <= (r_mu > MU_MAX) ? 20'd0
                                             : 20'(n_sym_sh) * 20'(SUBSLOT_SYMBOLS);
                    if (!r_act_in) begin
                        r_res_act <= 1'b0;
                        r_res_st  <= ST_INACTIVE;
                        r_state   <= S_DONE;
                    end else if (r_kind == KIND_DOWN
                                 || (r_kind == KIND_BIDI && r_role == ROLE_FIXED)) begin
                        r_len <= r_dlen;
                        if (r_dlen == 8'd0 && r_rep != REP_SINGLE) begin
                            r_res_act <= 1'b0;
                            r_res_st  <= ST_ZERO_LEN;
                            r_state   <= S_DONE;
                        end else begin
                            r_state   <= S_CHK;
                        end
                    end else if (r_kind == KIND_UP
                                 || (r_kind == KIND_BIDI && r_role == ROLE_PORTABLE)) begin
                        r_len <= r_ulen;
                        if (r_ulen == 8'd0 && r_rep != REP_SINGLE) begin
                            r_res_act <= 1'b0;
                            r_res_st  <= ST_ZERO_LEN;
                            r_state   <= S_DONE;
                        end else begin
                            r_state   <= S_CHK;
                        end
                    end else begin
                        r_res_act <= 1'b0;
                        r_res_st  <= ST_BAD_ALLOC;
                        r_state   <= S_DONE;
                    end
                end
                S_CHK: begin
                    r_span   <= 28'(r_len) * 28'(r_sub);
                    r_period <= n_rep_frame ? 32'(r_rcnt) * 32'(r_frame_ticks)
                                            : 32'(r_rcnt) * 32'(r_sub);
                    r_state  <= S_DEC;
                end
                S_DEC: begin
                    if (r_rep == REP_SINGLE) begin
                        r_state <= S_DONE;
                        if ((64'(r_next + {36'd0, r_span}) < r_now) && (r_next != 64'd0)) begin
                            r_res_act <= 1'b0;
                            r_res_st  <= ST_SINGLE_PAST;
                        end else begin
                            r_res_act <= 1'b1;
                            r_res_st  <= ST_SINGLE_PEND;
                        end
                    end else if (r_rcnt == 8'd0) begin
                        r_res_act <= 1'b0;
                        r_res_st  <= ST_ZERO_REPEAT;
                        r_state   <= S_DONE;
                    end else if (!n_rep_frame && !n_rep_sub) begin
                        r_res_act <= 1'b0;
                        r_res_st  <= ST_BAD_REPEAT;
                        r_state   <= S_DONE;
                    end else if (r_period == 32'd0) begin
                        r_res_act <= 1'b0;
                        r_res_st  <= ST_ZERO_PERIOD;
                        r_state   <= S_DONE;
                    end else if (r_next == 64'd0 && r_init) begin
                        r_next  <= r_now + {32'd0, r_period};
                        r_state <= S_FRM;
                    end else if (r_next <= r_now) begin
                        r_state <= S_DIV1;
                    end else begin
                        r_state <= S_FRM;
                    end
                end
                S_DIV1: begin
                    if (w_div_done) begin
                        r_next <= r_now - {32'd0, w_div_rem}
                                  + ((r_span == 28'd0 || w_div_rem != 32'd0)
                                     ? {32'd0, r_period} : 64'd0);
                        r_state <= S_FRM;
                    end
                end
                S_FRM: begin
                    r_neg <= n_diff[63];
                    if (r_valid == VALIDITY_UNLIMITED || r_first == FRAME_UNKNOWN) begin
                        r_res_act <= 1'b1;
                        r_res_st  <= ST_ADVANCED;
                        r_state   <= S_DONE;
                    end else if (r_frame_ticks == 24'd0) begin
                        r_frame <= FRAME_UNKNOWN;
                        r_state <= S_VAL;
                    end else begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (w_div_done) begin
                        r_frame <= r_neg ? 32'(32'd0 - n_q32) : n_q32;
                        r_state <= S_VAL;
                    end
                end
                S_VAL: begin
                    if (!n_elapsed[31] && (n_elapsed >= {24'd0, r_valid})) begin
                        r_res_act <= 1'b0;
                        r_res_st  <= ST_EXPIRED;
                    end else begin
                        r_res_act <= 1'b1;
                        r_res_st  <= ST_ADVANCED;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_act   <= r_res_act;
                        r_out_next  <= r_next;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.out_active    = r_out_act;
    assign o_res.out_next_time = r_out_next;
    assign o_res.status        = r_out_st;
endmodule
`default_nettype wire

### hdl/paa_checker.sv
// Port-level checker for periodic_allocation_advance_top and its bind.
// Depends on paa_pkg.
`default_nettype none
module paa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_res_valid,
    input wire logic        i_res_ready,
    input wire logic        i_res_active,
    input wire logic [63:0] i_res_next,
    input wire logic [3:0]  i_res_status
);
    import paa_pkg::*;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_next) && $stable(i_res_status))
        else $error("result payload changed while stalled");

    assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> i_req_ready)
        else $error("not ready after reset");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("ready while record in progress");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_active == (i_res_status == ST_ADVANCED
                                          || i_res_status == ST_SINGLE_PEND)))
        else $error("active flag inconsistent with status");
endmodule

bind periodic_allocation_advance_top paa_checker u_paa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_active (o_res.out_active),
    .i_res_next   (o_res.out_next_time),
    .i_res_status (o_res.status)
);
`default_nettype wire
